### src/pub_pkg.sv
`default_nettype none
package pub_pkg;
    localparam int PixW = 24;
    localparam int TrigOneBits = 14;
    localparam int CordicSteps = 14;

    localparam logic [0:0] OpLoad  = 1'b0;
    localparam logic [0:0] OpQuery = 1'b1;

    localparam logic [2:0] CfgCenter = 3'd0;
    localparam logic [2:0] CfgInner  = 3'd1;
    localparam logic [2:0] CfgHeight = 3'd2;
    localparam logic [2:0] CfgWidth  = 3'd3;
    localparam logic [2:0] CfgStep   = 3'd4;

    typedef logic [PixW-1:0] t_pix;

    typedef struct packed {
        logic [8:0]  center;
        logic [8:0]  inner;
        logic [9:0]  height;
        logic [11:0] width;
        logic [15:0] step;
    } t_cfg;

    // arctangent of 2^-i in 1/65536 turn
    function automatic logic [13:0] atan_lut(input int i);
        logic [13:0] v;
        case (i)
            0: v = 14'd8192;
            1: v = 14'd4836;
            2: v = 14'd2555;
            3: v = 14'd1297;
            4: v = 14'd651;
            5: v = 14'd326;
            6: v = 14'd163;
            7: v = 14'd81;
            8: v = 14'd41;
            9: v = 14'd20;
            10: v = 14'd10;
            11: v = 14'd5;
            12: v = 14'd3;
            13: v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

### src/pub_cordic.sv
`default_nettype none
// Pipelined rotation CORDIC: one step per stage, item per cycle while i_en is high.
module pub_cordic #(
    parameter int TagW = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [15:0]       i_ang,
    input  wire [TagW-1:0]   i_tag,
    output logic             o_valid,
    output logic signed [15:0] o_cos,
    output logic signed [15:0] o_sin,
    output logic [TagW-1:0]  o_tag
);
    import pub_pkg::*;

    localparam int N = CordicSteps;

    logic              r_v   [N+1];
    logic signed [15:0] r_x  [N+1];
    logic signed [15:0] r_y  [N+1];
    logic signed [17:0] r_z  [N+1];
    logic              r_neg [N+1];
    logic [TagW-1:0]   r_tag [N+1];

    logic signed [17:0] n_z0;
    logic              n_neg0;

    // fold the angle into the right half plane
    always_comb begin
        n_neg0 = 1'b0;
        if (i_ang >= 16'd16384 && i_ang < 16'd49152) begin
            n_z0   = $signed({2'b00, i_ang}) - 18'sd32768;
            n_neg0 = 1'b1;
        end else if (i_ang < 16'd16384) begin
            n_z0 = $signed({2'b00, i_ang});
        end else begin
            n_z0 = $signed({2'b00, i_ang}) - 18'sd65536;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]   <= 16'sd9949;
            r_y[0]   <= 16'sd0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
            r_tag[0] <= i_tag;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        logic signed [15:0] dx, dy;
        logic signed [17:0] at;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        assign at = $signed({4'b0000, atan_lut(g)});
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - at;
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + at;
                end
                r_neg[g+1] <= r_neg[g];
                r_tag[g+1] <= r_tag[g];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_cos   = r_neg[N] ? -r_x[N] : r_x[N];
    assign o_sin   = r_neg[N] ? -r_y[N] : r_y[N];
    assign o_tag   = r_tag[N];
endmodule
`default_nettype wire

### src/pub_store.sv
`default_nettype none
// Frame store: four banks by row and column parity, so one read of each
// bank yields all four neighbors of a 2x2 window together.
module pub_store #(
    parameter int SideBits = 9
) (
    input  wire               i_clk,
    input  wire               i_en,
    input  wire               i_we,
    input  wire [SideBits-1:0] i_wrow,
    input  wire [SideBits-1:0] i_wcol,
    input  wire [23:0]        i_wdata,
    input  wire [SideBits-1:0] i_rrow,
    input  wire [SideBits-1:0] i_rcol,
    output logic [23:0]       o_q00,
    output logic [23:0]       o_q01,
    output logic [23:0]       o_q10,
    output logic [23:0]       o_q11
);
    localparam int HB = SideBits - 1;
    localparam int Depth = 1 << (2 * HB);

    logic [23:0] r_m0 [Depth];
    logic [23:0] r_m1 [Depth];
    logic [23:0] r_m2 [Depth];
    logic [23:0] r_m3 [Depth];
    logic [23:0] r_d0, r_d1, r_d2, r_d3;
    logic        r_rp, r_cp;

    logic [SideBits-1:0] r1, c1;
    logic [HB-1:0] ra0, ra1, ca0, ca1;
    logic [2*HB-1:0] wa;
    assign r1  = i_rrow + 1'b1;
    assign c1  = i_rcol + 1'b1;
    // even-row address is the even one of (r, r+1)
    assign ra0 = i_rrow[0] ? r1[SideBits-1:1] : i_rrow[SideBits-1:1];
    assign ra1 = i_rrow[SideBits-1:1];
    assign ca0 = i_rcol[0] ? c1[SideBits-1:1] : i_rcol[SideBits-1:1];
    assign ca1 = i_rcol[SideBits-1:1];
    assign wa  = {i_wrow[SideBits-1:1], i_wcol[SideBits-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            case ({i_wrow[0], i_wcol[0]})
                2'b00: r_m0[wa] <= i_wdata;
                2'b01: r_m1[wa] <= i_wdata;
                2'b10: r_m2[wa] <= i_wdata;
                default: r_m3[wa] <= i_wdata;
            endcase
        end
        if (i_en) begin
            r_d0 <= r_m0[{ra0, ca0}];
            r_d1 <= r_m1[{ra0, ca1}];
            r_d2 <= r_m2[{ra1, ca0}];
            r_d3 <= r_m3[{ra1, ca1}];
            r_rp <= i_rrow[0];
            r_cp <= i_rcol[0];
        end
    end

    // steer banks back to window order
    always_comb begin
        case ({r_rp, r_cp})
            2'b00: begin o_q00 = r_d0; o_q01 = r_d1; o_q10 = r_d2; o_q11 = r_d3; end
            2'b01: begin o_q00 = r_d1; o_q01 = r_d0; o_q10 = r_d3; o_q11 = r_d2; end
            2'b10: begin o_q00 = r_d2; o_q01 = r_d3; o_q10 = r_d0; o_q11 = r_d1; end
            default: begin o_q00 = r_d3; o_q01 = r_d2; o_q10 = r_d1; o_q11 = r_d0; end
        endcase
    end
endmodule
`default_nettype wire

### src/polar_unwarp_bilinear_top.sv
// Channel   Dir  Contents
// s_axis    in   tdata: row[9:0] col[21:10] blue[29:22] green[37:30] red[45:38]; tuser: op
// m_axis    out  tdata: out_blue[7:0] out_green[15:8] out_red[23:16]
// cfg       in   i_cfg_index (register number), i_cfg_data
//
// One item per cycle while the pipe is not held. Stages: theta, a phase multiply,
// a 15-stage CORDIC (seed plus 14 rotations), two coordinate stages with the
// banked store read in the second, three blend stages and one skid entry.
// Loads ride the same pipe and write the store as they leave the CORDIC.
// The pipe holds only while the 2-entry skid buffer is full and its last
// stage has an item. Reset clears control only; the store is garbage until loaded.
`default_nettype none
module polar_unwarp_bilinear_top #(
    parameter int SRC_SIDE   = 512,
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // row, col, blue, green, red
    input  wire  [0:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_blue, out_green, out_red
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import pub_pkg::*;

    localparam int SB = $clog2(SRC_SIDE);
    localparam int FB = FRAC_BITS;
    localparam int TagW = 10 + 1 + 1 + 12 + PixW;  // row, zero flag, load flag, col, pixel
    localparam int SH = TrigOneBits - FB;
    localparam int PW = 9 + FB + 12; // px width signed

    t_cfg r_cfg;
    logic en;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{center: 9'd256, inner: 9'd128, height: 10'd256,
                       width: 12'd1500, step: 16'd44};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgCenter: r_cfg.center <= i_cfg_data[8:0];
                CfgInner:  r_cfg.inner  <= i_cfg_data[8:0];
                CfgHeight: r_cfg.height <= i_cfg_data[9:0];
                CfgWidth:  r_cfg.width  <= i_cfg_data[11:0];
                CfgStep:   r_cfg.step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input fields
    logic [9:0]  in_row;
    logic [11:0] in_col;
    logic        acc, is_load, is_q;
    logic        ld_ok;
    assign in_row = s_axis_tdata[9:0];
    assign in_col = s_axis_tdata[21:10];
    assign acc = s_axis_tvalid && s_axis_tready;
    assign is_load = acc && (s_axis_tuser == OpLoad);
    assign is_q    = acc && (s_axis_tuser == OpQuery);
    assign ld_ok = is_load && (in_row < SRC_SIDE) && (in_col < SRC_SIDE);

    // stage A: theta and zero decision; loads carry their write
    logic        r_av, r_az, r_ald;
    logic [9:0]  r_arow;
    logic [11:0] r_ath, r_acol;
    logic [PixW-1:0] r_apix;
    logic        n_zero;
    assign n_zero = ({1'b0, in_row} >= {1'b0, r_cfg.height} - 11'd1) ||
                    (r_cfg.height == 10'd0) || in_col == 12'd0 || in_col >= r_cfg.width;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (en) r_av <= is_q || ld_ok;
        if (en) begin
            r_arow <= in_row;
            r_az   <= n_zero;
            r_ath  <= r_cfg.width - 12'd1 - in_col;
            r_ald  <= ld_ok;
            r_acol <= in_col;
            r_apix <= s_axis_tdata[45:22];
        end
    end

    // stage B: phase multiply
    logic        r_bv;
    logic [TagW-1:0] r_btag;
    logic [15:0] r_bang;
    logic [27:0] prod;
    logic [ANGLE_BITS-1:0] phase;
    logic [15:0] ang;
    assign prod  = r_ath * r_cfg.step;
    assign phase = ANGLE_BITS'(prod);
    if (ANGLE_BITS >= 16) begin : g_ahi
        assign ang = 16'(phase >> (ANGLE_BITS - 16));
    end else begin : g_alo
        assign ang = 16'({phase, {(16 - ANGLE_BITS){1'b0}}});
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (en) r_bv <= r_av;
        if (en) begin
            r_bang <= ang;
            r_btag <= {r_apix, r_acol, r_ald, r_az, r_arow};
        end
    end

    logic        cv;
    logic signed [15:0] cc, cs;
    logic [TagW-1:0] ctag;
    pub_cordic #(.TagW(TagW)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_bv),
        .i_ang(r_bang), .i_tag(r_btag),
        .o_valid(cv), .o_cos(cc), .o_sin(cs), .o_tag(ctag)
    );

    // stage D: radius times trig; loads leave the pipe here
    logic        r_dv, r_dz;
    logic signed [27:0] r_mx, r_my;
    logic signed [11:0] rad;
    assign rad = $signed({1'b0, {1'b0, ctag[9:0]} + {2'b00, r_cfg.inner}});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else if (en) r_dv <= cv && !ctag[11];
        if (en) begin
            r_mx <= 28'(rad * cc);
            r_my <= 28'(rad * cs);
            r_dz <= ctag[10];
        end
    end

    // stage E: source point, integer and fraction
    logic signed [PW-1:0] px, py;
    logic signed [PW-FB-1:0] xi, yi;
    assign px = $signed({{(PW-9-FB){1'b0}}, r_cfg.center, {FB{1'b0}}}) + PW'(r_mx >>> SH);
    assign py = $signed({{(PW-9-FB){1'b0}}, r_cfg.center, {FB{1'b0}}}) + PW'(r_my >>> SH);
    assign xi = px[PW-1:FB];
    assign yi = py[PW-1:FB];

    // neighbor bounds, bit 0 is base, bit 1 is base+1
    logic [1:0] okx, oky;
    assign okx[0] = (xi >= 0) && (xi < SRC_SIDE);
    assign okx[1] = (xi >= -1) && (xi < SRC_SIDE - 1);
    assign oky[0] = (yi >= 0) && (yi < SRC_SIDE);
    assign oky[1] = (yi >= -1) && (yi < SRC_SIDE - 1);

    logic        r_ev, r_ez;
    logic [3:0]  r_eok;
    logic [FB-1:0] r_efx, r_efy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else if (en) r_ev <= r_dv;
        if (en) begin
            r_ez  <= r_dz;
            r_efx <= px[FB-1:0];
            r_efy <= py[FB-1:0];
            r_eok <= {oky[1] & okx[1], oky[1] & okx[0], oky[0] & okx[1], oky[0] & okx[0]};
        end
    end

    // store: a load writes one stage ahead of the read, so reads see loads in item order
    logic [23:0] q00, q01, q10, q11;
    logic st_we;
    assign st_we = en && cv && ctag[11];
    pub_store #(.SideBits(SB)) u_store (
        .i_clk(i_clk), .i_en(en), .i_we(st_we),
        .i_wrow(SB'(ctag[9:0])), .i_wcol(SB'(ctag[23:12])), .i_wdata(ctag[47:24]),
        .i_rrow(SB'(yi)), .i_rcol(SB'(xi)),
        .o_q00(q00), .o_q01(q01), .o_q10(q10), .o_q11(q11)
    );

    // stage F: weights and masked pixels
    logic [FB:0] ofx, ofy;
    assign ofx = (FB+1)'(1 << FB) - {1'b0, r_efx};
    assign ofy = (FB+1)'(1 << FB) - {1'b0, r_efy};
    logic        r_fv, r_fz;
    logic [2*FB+1:0] r_w [4];
    logic [23:0] r_p [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (en) r_fv <= r_ev;
        if (en) begin
            r_fz   <= r_ez;
            r_w[0] <= ofx * ofy;
            r_w[1] <= {1'b0, r_efx} * ofy;
            r_w[2] <= ofx * {1'b0, r_efy};
            r_w[3] <= {1'b0, r_efx} * {1'b0, r_efy};
            r_p[0] <= r_eok[0] ? q00 : 24'd0;
            r_p[1] <= r_eok[1] ? q01 : 24'd0;
            r_p[2] <= r_eok[2] ? q10 : 24'd0;
            r_p[3] <= r_eok[3] ? q11 : 24'd0;
        end
    end

    // stage G: products; stage H: sum and truncate
    localparam int SW = 2*FB + 2 + 8;
    logic        r_gv, r_gz, r_hv;
    logic [SW-1:0] r_pr [4][3];
    logic [23:0] r_h;
    logic [23:0] n_h;
    always_comb begin
        logic [SW+1:0] s;
        for (int c = 0; c < 3; c++) begin
            s = (SW+2)'(r_pr[0][c]) + (SW+2)'(r_pr[1][c]) +
                (SW+2)'(r_pr[2][c]) + (SW+2)'(r_pr[3][c]);
            n_h[8*c +: 8] = r_gz ? 8'd0 : s[2*FB +: 8];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
            r_hv <= 1'b0;
        end else if (en) begin
            r_gv <= r_fv;
            r_hv <= r_gv;
        end
        if (en) begin
            r_gz <= r_fz;
            for (int k = 0; k < 4; k++)
                for (int c = 0; c < 3; c++)
                    r_pr[k][c] <= SW'(r_w[k] * r_p[k][8*c +: 8]);
            r_h <= n_h;
        end
    end

    // output skid: two entries, pipe holds only when full with an item behind it
    logic [23:0] r_s0, r_s1;
    logic [1:0]  r_cnt;
    logic        pop, push;
    assign en = (r_cnt != 2'd2) || !r_hv;
    assign s_axis_tready = en;
    assign push = r_hv && en;
    assign m_axis_tvalid = r_cnt != 2'd0;
    assign m_axis_tdata = r_s0;
    assign pop = m_axis_tvalid && m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (pop) begin
            r_s0 <= (r_cnt == 2'd2) ? r_s1 : r_h;
            if (push) r_s1 <= r_h;
        end else if (push) begin
            if (r_cnt == 2'd0) r_s0 <= r_h;
            else r_s1 <= r_h;
        end
    end
endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pub_pkg::*;

    localparam int Side = 512;
    localparam int FracBits = 8;
    localparam int IdleLimit = 5000;
    localparam int HoldCycles = 400;
    localparam logic [2:0] CfgSpare = 3'd5;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [0:0]  op;
        logic [9:0]  row;
        logic [11:0] col;
        t_rgb        pix;
        logic        typed;
        t_rgb        want;
    } t_stim;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    polar_unwarp_bilinear_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block's registers and frame store
    int   center_r, inner_r, height_r, width_r, step_r;
    t_rgb src_mem [Side*Side];
    bit   loaded  [Side*Side];
    t_rgb pixel_q [$];

    int  errors;
    int  idle_cycles;
    bit  no_idle;
    bit  hold_req;
    int  hold_left;

    // atan(2^-i) in 1/65536 turn
    const int atan_steps [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1};

    localparam t_stim DIRECTED [14] = '{
        '{OpLoad,  10'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h0},
        '{OpLoad,  10'd511,  12'd511,  24'h000000, 1'b0, 24'h0},
        '{OpLoad,  10'd1023, 12'd4095, 24'hAAAAAA, 1'b0, 24'h0},
        '{OpLoad,  10'd0,    12'd600,  24'h555555, 1'b0, 24'h0},
        '{OpLoad,  10'd700,  12'd3,    24'h123456, 1'b0, 24'h0},
        '{OpQuery, 10'd0,    12'd0,    24'hFFFFFF, 1'b1, 24'h0},
        '{OpQuery, 10'd1023, 12'd4095, 24'hFFFFFF, 1'b1, 24'h0},
        '{OpQuery, 10'd255,  12'd5,    24'h0,      1'b1, 24'h0},
        '{OpQuery, 10'd254,  12'd1500, 24'h0,      1'b1, 24'h0},
        '{OpQuery, 10'd254,  12'd1499, 24'h0,      1'b0, 24'h0},
        '{OpQuery, 10'd0,    12'd1,    24'h0,      1'b0, 24'h0},
        '{OpQuery, 10'd100,  12'd750,  24'h0,      1'b0, 24'h0},
        '{OpQuery, 10'd0,    12'd1125, 24'h0,      1'b0, 24'h0},
        '{OpQuery, 10'd253,  12'd375,  24'h0,      1'b0, 24'h0}
    };

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // cos and sin in Q14 of a 16-bit turn fraction
    function automatic void turn_to_trig(input int ang, output int c, output int s);
        int x, y, z, dx, dy;
        bit flip;
        x = 9949;
        y = 0;
        flip = 0;
        if (ang >= 16384 && ang < 49152) begin
            z = ang - 32768;
            flip = 1;
        end else if (ang < 16384) begin
            z = ang;
        end else begin
            z = ang - 65536;
        end
        for (int i = 0; i < 14; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_steps[i];
            end else begin
                x += dx; y -= dy; z += atan_steps[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic bit blanked(input int row, input int col);
        return (row >= height_r - 1) || (col == 0) || (col >= width_r);
    endfunction

    // source point of a panorama pixel, integer and fraction parts
    function automatic void locate(input int row, input int col,
                                   output int xi, output int yi,
                                   output int fx, output int fy);
        int unsigned theta, phase;
        int c, s, rad, px, py;
        theta = width_r - 1 - col;
        phase = (theta * step_r) & 32'hFFFF;
        turn_to_trig(phase, c, s);
        rad = row + inner_r;
        px = (center_r << FracBits) + ((rad * c) >>> (TrigOneBits - FracBits));
        py = (center_r << FracBits) + ((rad * s) >>> (TrigOneBits - FracBits));
        xi = px >>> FracBits;
        yi = py >>> FracBits;
        fx = px & ((1 << FracBits) - 1);
        fy = py & ((1 << FracBits) - 1);
    endfunction

    function automatic t_rgb fetch_pix(input int y, input int x);
        if (x < 0 || y < 0 || x >= Side || y >= Side) return '0;
        return src_mem[y*Side + x];
    endfunction

    function automatic t_rgb unwarp_pixel(input int row, input int col);
        int xi, yi, fx, fy, one;
        int w [4];
        t_rgb p [4];
        int sb, sg, sr;
        if (blanked(row, col)) return '0;
        locate(row, col, xi, yi, fx, fy);
        one = 1 << FracBits;
        w[0] = (one - fx) * (one - fy);
        w[1] = fx * (one - fy);
        w[2] = (one - fx) * fy;
        w[3] = fx * fy;
        p[0] = fetch_pix(yi, xi);
        p[1] = fetch_pix(yi, xi + 1);
        p[2] = fetch_pix(yi + 1, xi);
        p[3] = fetch_pix(yi + 1, xi + 1);
        sb = 0; sg = 0; sr = 0;
        for (int k = 0; k < 4; k++) begin
            sb += w[k] * int'(p[k].blue);
            sg += w[k] * int'(p[k].green);
            sr += w[k] * int'(p[k].red);
        end
        return '{red: 8'(sr >> (2*FracBits)), green: 8'(sg >> (2*FracBits)),
                 blue: 8'(sb >> (2*FracBits))};
    endfunction

    // offer one item and hold it until taken
    task automatic send(input logic [0:0] op, input int row, input int col, input t_rgb pix);
        if (!no_idle && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, pix, col[11:0], row[9:0]};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_pixel(input int row, input int col, input t_rgb pix);
        send(OpLoad, row, col, pix);
        if (row < Side && col < Side) begin
            src_mem[row*Side + col] = pix;
            loaded[row*Side + col]  = 1'b1;
        end
    endtask

    // fill any unwritten neighbor of a query's source point first
    task automatic query_pixel(input int row, input int col, input bit typed, input t_rgb want);
        int xi, yi, fx, fy, nx, ny;
        if (!blanked(row, col)) begin
            locate(row, col, xi, yi, fx, fy);
            for (int k = 0; k < 4; k++) begin
                nx = xi + (k & 1);
                ny = yi + (k >> 1);
                if (nx >= 0 && ny >= 0 && nx < Side && ny < Side && !loaded[ny*Side + nx])
                    load_pixel(ny, nx, t_rgb'($urandom));
            end
        end
        pixel_q.push_back(typed ? want : unwarp_pixel(row, col));
        send(OpQuery, row, col, t_rgb'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgCenter: center_r = value & 32'h1FF;
            CfgInner:  inner_r  = value & 32'h1FF;
            CfgHeight: height_r = value & 32'h3FF;
            CfgWidth:  width_r  = value & 32'hFFF;
            CfgStep:   step_r   = value & 32'hFFFF;
            default: ;
        endcase
    endtask

    // wait out every result, then the pipe's tail of loads
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_regs(input int c, input int r, input int h, input int w, input int st);
        drain();
        write_reg(CfgCenter, c);
        write_reg(CfgInner, r);
        write_reg(CfgHeight, h);
        write_reg(CfgWidth, w);
        write_reg(CfgStep, st);
    endtask

    task automatic random_items(input int count);
        int row, col;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 30) begin
                row = ($urandom_range(3) != 0) ? $urandom_range(Side-1) : $urandom_range(1023);
                col = ($urandom_range(3) != 0) ? $urandom_range(Side-1) : $urandom_range(4095);
                load_pixel(row, col, t_rgb'($urandom));
            end else begin
                if ($urandom_range(99) < 80) begin
                    row = $urandom_range(height_r > 0 ? height_r - 1 : 0);
                    col = $urandom_range(width_r > 0 ? width_r - 1 : 0);
                end else begin
                    row = $urandom_range(1023);
                    col = $urandom_range(4095);
                end
                query_pixel(row, col, 1'b0, '0);
            end
        end
    endtask

    // receiver: check each result, then pick next ready
    initial begin
        t_rgb got, want;
        m_axis_tready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pixel_q.size() == 0) begin
                    report("unexpected item", int'(got), 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (got.blue != want.blue)
                        report("out_blue", int'(got.blue), int'(want.blue));
                    if (got.green != want.green)
                        report("out_green", int'(got.green), int'(want.green));
                    if (got.red != want.red)
                        report("out_red", int'(got.red), int'(want.red));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= i_rst_n && (no_idle || $urandom_range(99) >= 18);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int w;
        errors = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OpLoad;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgCenter;
        i_cfg_data = '0;
        center_r = 256; inner_r = 128; height_r = 256; width_r = 1500; step_r = 44;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows at reset settings
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].op == OpLoad)
                load_pixel(DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].pix);
            else
                query_pixel(DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].typed,
                            DIRECTED[i].want);
        end
        random_items(70);

        // low extremes, plus a write to an unused index
        set_regs(0, 0, 2, 2, 0);
        write_reg(CfgSpare, 16'hFFFF);
        query_pixel(0, 1, 1'b0, '0);
        query_pixel(1, 1, 1'b1, '0);
        random_items(35);

        // high extremes
        set_regs(511, 511, 1023, 4095, 65535);
        random_items(55);

        for (int ph = 0; ph < 4; ph++) begin
            w = $urandom_range(4095, 2);
            set_regs($urandom_range(360, 150), $urandom_range(120), $urandom_range(300, 2), w,
                     ($urandom_range(1) != 0) ? 65536 / w : $urandom_range(65535));
            if (ph == 0) hold_req = 1'b1;
            no_idle = (ph == 1);
            random_items(95);
        end
        no_idle = 1'b0;

        drain();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
